@@ rtl/dnle_pkg.sv @@
package dnle_pkg;

    localparam int MAX_LABEL_DEF = 32;
    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef struct packed {
        logic store;
        logic emit_len;
        logic emit_data;
        logic emit_term;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic cnt_zero;
        logic data_last;
    } t_stat;

endpackage

@@ rtl/dnle_ctrl.sv @@
module dnle_ctrl
    import dnle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_char_valid,
    input  logic       i_name_end,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLUSH,
        S_BYTES,
        S_TERM
    } t_state;

    t_state r_state, n_state;
    logic   r_second, n_second;
    logic   r_term, n_term;
    logic   w_accept;
    logic   w_is_dot;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_is_dot   = (i_char_in == DOT_CHAR);

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        n_term   = r_term;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.store = i_char_valid && !w_is_dot;
                    if (i_char_valid && w_is_dot) begin
                        n_state  = S_FLUSH;
                        n_second = i_name_end;
                        n_term   = i_name_end;
                    end else if (i_name_end) begin
                        n_state  = S_FLUSH;
                        n_second = 1'b0;
                        n_term   = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_len = 1'b1;
                    o_cmd.last     = i_stat.cnt_zero && !r_second && !r_term;
                    if (!i_stat.cnt_zero) begin
                        n_state = S_BYTES;
                    end else if (r_second) begin
                        n_second = 1'b0;
                        n_state  = S_FLUSH;
                    end else if (r_term) begin
                        n_state = S_TERM;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_BYTES: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_data = 1'b1;
                    o_cmd.last      = i_stat.data_last && !r_second && !r_term;
                    if (i_stat.data_last) begin
                        if (r_second) begin
                            n_second = 1'b0;
                            n_state  = S_FLUSH;
                        end else if (r_term) begin
                            n_state = S_TERM;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_TERM: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_term = 1'b1;
                    o_cmd.last      = 1'b1;
                    n_term          = 1'b0;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
            r_term   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_term   <= n_term;
        end
    end

    // A second flush is only pending together with a terminator.
    a_second_implies_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> r_term)
        else $error("second flush pending without terminator");

    // The terminator state is only reached with a terminator pending.
    a_term_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TERM) |-> (r_term && !r_second))
        else $error("terminator state without pending terminator");

    // A word is never emitted while the output register is blocked.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_len || o_cmd.emit_data || o_cmd.emit_term) |-> i_stat.out_free)
        else $error("emit while output register is blocked");

endmodule

@@ rtl/dnle_dp.sv @@
module dnle_dp
    import dnle_pkg::*;
#(
    parameter int MAX_LABEL = MAX_LABEL_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_char_in,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_length,
    output logic       o_run_last,
    output logic       o_name_done,
    output logic       o_overflow
);

    localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int CW = $clog2(MAX_LABEL + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LABEL);

    logic [7:0]    r_mem [MAX_LABEL];
    logic [7:0]    r_rd_data;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_rd_idx;
    logic          r_ovf;
    logic          r_out_valid;
    logic          w_emit;
    logic          w_room;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;

    assign w_emit = i_cmd.emit_len || i_cmd.emit_data || i_cmd.emit_term;
    assign w_room = (r_cnt < CNT_MAX);

    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.data_last = (r_rd_idx == r_len);

    assign w_rd_en   = (i_cmd.emit_len && (r_cnt != '0))
                    || (i_cmd.emit_data && (r_rd_idx != r_len));
    assign w_rd_addr = i_cmd.emit_len ? '0 : r_rd_idx[AW-1:0];

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && w_room) begin
            r_mem[r_cnt[AW-1:0]] <= i_char_in;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_len       <= '0;
            r_rd_idx    <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                if (w_room) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.emit_len) begin
                r_len    <= r_cnt;
                r_cnt    <= '0;
                r_rd_idx <= CW'(1);
            end
            if (i_cmd.emit_data && (r_rd_idx != r_len)) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (i_cmd.emit_term) begin
                r_ovf <= 1'b0;
                r_cnt <= '0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_out_byte  <= i_cmd.emit_len ? 8'(r_cnt)
                         : (i_cmd.emit_data ? r_rd_data : 8'h00);
            o_is_length <= i_cmd.emit_len || i_cmd.emit_term;
            o_run_last  <= i_cmd.last;
            o_name_done <= i_cmd.emit_term;
            o_overflow  <= r_ovf;
        end
    end

    // Storing a character and emitting a word never happen together.
    a_store_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> !w_emit)
        else $error("store coincides with emit");

    // The label count never passes the buffer depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CNT_MAX) && (r_len <= CNT_MAX))
        else $error("label count beyond buffer depth");

    // The overflow flag is cleared once the terminator has been emitted.
    a_ovf_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_term |=> (!r_ovf && (r_cnt == '0)))
        else $error("state not cleared after terminator");

endmodule

@@ rtl/dns_name_label_encoder_core.sv @@
// DNS name label encoder: turns a dotted domain name into wire-format labels.
// Input channel (i_in_valid / o_in_stall): one character per word, with
// i_char_valid low only for an empty name and i_name_end high on the last word.
// Output channel (o_out_valid / i_out_stall): one encoded byte per word, with
// flags for length bytes, the last word caused by an input word, the
// terminating zero and a label overflow seen in the current name.
// Ordinary characters are buffered at one word per cycle with no output.
// A dot or the end of the name flushes the buffered label: the length byte
// first, then each buffered character, read from the label memory one
// address per cycle; a name end then adds the terminator byte.
// Input is stalled while a flush is in progress.
// Characters beyond MAX_LABEL in one label are dropped and raise the overflow
// flag until the terminator. Reset empties the label buffer and the output
// register. When the receiver stalls, the output word holds and the flush
// pauses, which in turn keeps the input stalled.
module dns_name_label_encoder_core
    import dnle_pkg::*;
#(
    parameter int MAX_LABEL = MAX_LABEL_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_char_valid,
    input  logic       i_name_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_length,
    output logic       o_run_last,
    output logic       o_name_done,
    output logic       o_overflow
);

    t_cmd  w_cmd;
    t_stat w_stat;

    dnle_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_char_in    (i_char_in),
        .i_char_valid (i_char_valid),
        .i_name_end   (i_name_end),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    dnle_dp #(
        .MAX_LABEL (MAX_LABEL)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_in   (i_char_in),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_is_length (o_is_length),
        .o_run_last  (o_run_last),
        .o_name_done (o_name_done),
        .o_overflow  (o_overflow)
    );

endmodule
